[sv/aclru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclru_pkg
// Shared constants and types for the aging-counter LRU replacement policy.
// ----------------------------------------------------------------------------
package aclru_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W   = 64;
	localparam int CNT_W   = 32;
	localparam int ENTRY_W = 4;

	typedef struct packed {
		logic               lookup_hit;
		logic [ENTRY_W-1:0] found_index;
	} req_t;

	typedef struct packed {
		logic               was_hit;
		logic [ENTRY_W-1:0] entry_index;
		logic [CNT_W-1:0]   hit_total;
		logic [CNT_W-1:0]   miss_total;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
	} sts_t;

endpackage

[sv/aclru_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclru_ctrl
// Sequencer: takes a transaction, walks the age sweep, then issues the update.
// ----------------------------------------------------------------------------
module aclru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  aclru_pkg::sts_t   sts,
	output aclru_pkg::cmd_t   cmd
);
	import aclru_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.step    = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[sv/aclru_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclru_dp
// Age registers, shared 64-bit incrementer and oldest-entry tracker,
// hit/miss counters and the result register.
// ----------------------------------------------------------------------------
module aclru_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  aclru_pkg::cmd_t   cmd,
	output aclru_pkg::sts_t   sts,
	input  aclru_pkg::req_t   req,
	output logic              done,
	output aclru_pkg::res_t   res
);
	import aclru_pkg::*;

	logic [AGE_W-1:0] age_q [ENTRIES];
	logic [IDX_W-1:0] sweep_cnt_q;
	logic [AGE_W-1:0] oldest_age_q;
	logic [IDX_W-1:0] oldest_idx_q;
	logic             hit_q;
	logic [ENTRY_W-1:0] idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic             done_q;
	res_t             res_q;

	logic [AGE_W-1:0] aged;
	logic             hit_ok;
	logic [IDX_W-1:0] chosen;
	logic [CNT_W-1:0] hit_cnt_d;
	logic [CNT_W-1:0] miss_cnt_d;

	assign aged   = age_q[sweep_cnt_q] + AGE_W'(1);
	// hit with an index past the last entry counts as a miss
	assign hit_ok = hit_q && (32'(idx_q) < 32'(ENTRIES));
	assign chosen = hit_ok ? IDX_W'(idx_q) : oldest_idx_q;
	assign hit_cnt_d  = hit_ok ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
	assign miss_cnt_d = hit_ok ? miss_cnt_q : miss_cnt_q + CNT_W'(1);

	assign sts.sweep_last = (sweep_cnt_q == IDX_W'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (cmd.step) begin
			age_q[sweep_cnt_q] <= aged;
		end else if (cmd.finish) begin
			age_q[chosen] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hit_q        <= req.lookup_hit;
			idx_q        <= req.found_index;
			sweep_cnt_q  <= '0;
			oldest_age_q <= '0;
			oldest_idx_q <= '0;
		end else if (cmd.step) begin
			sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
			// strict compare keeps the lowest index among equal ages
			if (aged > oldest_age_q) begin
				oldest_age_q <= aged;
				oldest_idx_q <= sweep_cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				hit_cnt_q  <= hit_cnt_d;
				miss_cnt_q <= miss_cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.was_hit     <= hit_ok;
			res_q.entry_index <= ENTRY_W'(chosen);
			res_q.hit_total   <= hit_cnt_d;
			res_q.miss_total  <= miss_cnt_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[sv/aging_counter_lru_policy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_counter_lru_policy
// Aging-counter LRU replacement policy for a 16-entry fully associative cache.
// ----------------------------------------------------------------------------
// A transaction is taken by start when busy is low; busy then stays high
// through the sweep, in which a single 64-bit incrementer and comparator
// ages one entry per cycle and tracks the oldest, and the update state, and
// the result appears on res with done high for exactly one cycle, the first
// cycle with busy low again. The receiver cannot stall: the result must be
// taken in that cycle. A new start may be given in that same cycle.
module aging_counter_lru_policy (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  aclru_pkg::req_t req,
	output logic            done,
	output aclru_pkg::res_t res
);
	import aclru_pkg::*;

	cmd_t cmd;
	sts_t sts;

	aclru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	aclru_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.done   (done),
		.res    (res)
	);

endmodule

[sv/aclru_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aclru_chk
// Port-level checks for the aging-counter LRU policy, bound to the top level.
// ----------------------------------------------------------------------------
module aclru_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input aclru_pkg::res_t res
);
	import aclru_pkg::*;

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted transaction");

	// results come only while the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// one strobe per transaction, never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// no result right after a fresh transaction is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result one cycle after accept");

	// a result carries no unknown bits
	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(res))
		else $error("unknown bits on result");

endmodule

bind aging_counter_lru_policy aclru_chk u_aclru_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

[test/aging_counter_lru_policy_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_counter_lru_policy_test
// Self-checking bench for the aging-counter LRU replacement policy. A tracker
// keeps its own ages and hit/miss counts, predicts the result of every
// accepted lookup, and compares each done pulse field by field against the
// oldest prediction. A short directed run comes first, then random hit/miss
// traffic with bursts of idle on the start side.
// ----------------------------------------------------------------------------
module aging_counter_lru_policy_test;
	import aclru_pkg::*;

	class replacement_tracker;
		bit [AGE_W-1:0] entry_age [ENTRIES];
		bit [CNT_W-1:0] hit_count;
		bit [CNT_W-1:0] miss_count;
		res_t           pending_outcomes [$];
		int unsigned    faults;

		function res_t age_and_select(req_t rq);
			res_t           outcome;
			bit [AGE_W-1:0] oldest_age;
			int             oldest_idx;
			int             chosen;
			bit             hit;
			oldest_age = '0;
			oldest_idx = 0;
			// strict compare keeps the lowest index among equal ages
			for (int i = 0; i < ENTRIES; i++) begin
				entry_age[i] = entry_age[i] + 1'b1;
				if (entry_age[i] > oldest_age) begin
					oldest_age = entry_age[i];
					oldest_idx = i;
				end
			end
			hit = rq.lookup_hit && (int'(rq.found_index) < ENTRIES);
			if (hit) begin
				chosen = int'(rq.found_index);
				hit_count = hit_count + 1'b1;
			end else begin
				chosen = oldest_idx;
				miss_count = miss_count + 1'b1;
			end
			entry_age[chosen] = '0;
			outcome.was_hit     = hit;
			outcome.entry_index = chosen[ENTRY_W-1:0];
			outcome.hit_total   = hit_count;
			outcome.miss_total  = miss_count;
			return outcome;
		endfunction

		function void note_access(req_t rq);
			pending_outcomes.push_back(age_and_select(rq));
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		function void compare_field(string field, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
				faults++;
			end
		endfunction

		function void check_outcome(res_t got);
			res_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time, got);
				faults++;
				return;
			end
			want = pending_outcomes.pop_front();
			compare_field("was_hit", CNT_W'(want.was_hit), CNT_W'(got.was_hit));
			compare_field("entry_index", CNT_W'(want.entry_index), CNT_W'(got.entry_index));
			compare_field("hit_total", want.hit_total, got.hit_total);
			compare_field("miss_total", want.miss_total, got.miss_total);
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	res_t  res;

	replacement_tracker tracker;

	aging_counter_lru_policy u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// the receiver cannot stall, so every done pulse is a transaction
	always @(posedge clk) begin
		if (done === 1'b1)
			tracker.check_outcome(res);
	end

	task automatic send_lookup(input logic hit, input logic [ENTRY_W-1:0] idx);
		req_t rq;
		rq.lookup_hit  = hit;
		rq.found_index = idx;
		@(negedge clk);
		start <= 1'b1;
		req   <= rq;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		tracker.note_access(rq);
	endtask

	// start low, with junk on req while nothing is offered; n sets the pause length
	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			req   <= req_t'($urandom);
		end
	endtask

	task automatic wait_for_drain();
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int                 hot_base;
		int                 mode;
		bit                 idling;
		logic [ENTRY_W-1:0] idx;
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		req     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// all ages tie after reset: victims walk up from entry 0
		send_lookup(1'b0, 4'd0);
		send_lookup(1'b0, 4'd15);
		send_lookup(1'b0, 4'd10);
		send_lookup(1'b1, 4'd0);
		send_lookup(1'b1, 4'd15);
		send_lookup(1'b1, 4'd15);
		send_lookup(1'b1, 4'd5);
		send_lookup(1'b1, 4'd10);
		pause_sender(3);
		send_lookup(1'b0, 4'd5);
		send_lookup(1'b0, 4'd0);
		send_lookup(1'b1, 4'd3);
		send_lookup(1'b0, 4'd15);
		send_lookup(1'b1, 4'd12);
		send_lookup(1'b1, 4'd1);
		send_lookup(1'b0, 4'd7);
		send_lookup(1'b0, 4'd8);
		pause_sender(13);
		send_lookup(1'b1, 4'd8);
		send_lookup(1'b0, 4'd0);
		send_lookup(1'b0, 4'd0);
		send_lookup(1'b1, 4'd2);

		pause_sender(1);
		wait_for_drain();

		hot_base = 0;
		idling   = 1'b1;
		for (int n = 0; n < 1680; n++) begin
			if (n % 100 == 0)
				hot_base = $urandom_range(0, ENTRIES - 1);
			if (n % 64 == 0)
				idling = ($urandom_range(0, 3) != 0);
			if (n % 400 == 399) begin
				pause_sender(1);
				wait_for_drain();
			end
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				send_lookup(1'b0, ENTRY_W'($urandom));
			end else if (mode < 7) begin
				send_lookup(1'b1, ENTRY_W'($urandom));
			end else begin
				// hits on a few hot entries push the rest toward eviction
				idx = ENTRY_W'(hot_base + $urandom_range(0, 2));
				send_lookup(1'b1, idx);
			end
			if (idling && n < 1480 && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 13));
		end

		pause_sender(1);
		wait_for_drain();
		repeat (40) @(posedge clk);
		if (tracker.faults == 0 && tracker.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(64'd5_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
